@@ rtl/mvsm_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and helpers of the sample mixer.
// Used by the front, the queue, the back and the top level; depends on nothing.
package mvsm_pkg;

   // Default sizes of the top level parameters
   localparam int VOICES_DEF       = 4;
   localparam int SAMPLE_WORDS_DEF = 4096;
   localparam int SAMPLE_BITS_DEF  = 8;

   // Fixed field widths of the ports
   localparam int MODE_W      = 2;
   localparam int ADDR_W      = 12;
   localparam int SVAL_W      = 8;
   localparam int LEN_W       = 12;
   localparam int SONG_W      = 11;
   localparam int SONG_HALF_W = SONG_W - 1;
   localparam int AUDIO_W     = 12;
   localparam int USED_W      = 2;
   localparam int DIV_W       = 4;
   localparam int HELD_W      = 11;

   localparam logic [DIV_W-1:0]  DIVIDER_RESET = 4'd4;
   localparam logic [HELD_W-1:0] HELD_MAX      = 11'h7FF;

   // Input mode codes
   localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_START = 2'd1;
   localparam logic [MODE_W-1:0] MODE_TICK  = 2'd2;

   // Address wrap: base plus position is below 8192, and the store holds at
   // least 256 words, so five conditional subtracts bring it into range.
   localparam int ADDR_SUM_W = ADDR_W + 1;
   localparam int WRAP_STEPS = 5;
   localparam int WRAP_W     = 22;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = 1;
   localparam int QUEUE_CNT_W = 2;

   typedef enum logic [1:0] {
      OP_LOAD,
      OP_START,
      OP_TICK,
      OP_NONE
   } op_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_READ,
      BK_ACC,
      BK_DONE
   } back_state_type;

   // One classified item on its way from front to back
   typedef struct packed {
      op_type                 op;
      logic [ADDR_W-1:0]      address;
      logic [SVAL_W-1:0]      sample_value;
      logic [LEN_W-1:0]       effect_length;
      logic                   length_zero;
      logic [SONG_HALF_W-1:0] song_half;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Reduce an address sum modulo the store size by shifted subtracts
   function automatic logic [ADDR_SUM_W-1:0] wrap_addr(
      input logic [ADDR_SUM_W-1:0] x,
      input int unsigned           words
   );
      logic [WRAP_W-1:0] r;
      logic [WRAP_W-1:0] lim;
      r = WRAP_W'(x);
      for (int k = WRAP_STEPS - 1; k >= 0; k--) begin
         lim = WRAP_W'(words) << k;
         if (r >= lim) begin
            r = r - lim;
         end
      end
      return ADDR_SUM_W'(r);
   endfunction

endpackage

@@ rtl/mvsm_front.sv @@
`timescale 1ns / 1ps
// Front part of the mixer: takes request items and classifies them.
// Depends on mvsm_pkg; feeds mvsm_queue.
module mvsm_front import mvsm_pkg::*; (
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [MODE_W-1:0]     req_mode,
   input  logic [ADDR_W-1:0]     req_address,
   input  logic [SVAL_W-1:0]     req_sample_value,
   input  logic [LEN_W-1:0]      req_effect_length,
   input  logic [SONG_W-1:0]     req_song_sample,
   input  queue_status_type      q_status,
   output logic                  push,
   output entry_type             push_entry
);

   op_type op;

   // Decode the mode into an operation
   always_comb begin
      unique case (req_mode)
         MODE_LOAD:  op = OP_LOAD;
         MODE_START: op = OP_START;
         MODE_TICK:  op = OP_TICK;
         default:    op = OP_NONE;
      endcase
   end

   // Accept whenever the queue has room
   assign req_ready = !q_status.full;
   assign push      = req_valid && !q_status.full;

   // Build the queue item
   always_comb begin
      push_entry.op            = op;
      push_entry.address       = req_address;
      push_entry.sample_value  = req_sample_value;
      push_entry.effect_length = req_effect_length;
      push_entry.length_zero   = (req_effect_length == '0);
      push_entry.song_half     = req_song_sample[SONG_W-1:1];
   end

endmodule

@@ rtl/mvsm_queue.sv @@
`timescale 1ns / 1ps
// Two-entry queue between the front and the back of the mixer.
// Depends on mvsm_pkg for the item type.
module mvsm_queue import mvsm_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  entry_type        push_entry,
   input  logic             pop,
   output entry_type        pop_entry,
   output queue_status_type status
);

   entry_type               slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]  wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0]  wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]  rd_ptr_ff;
   logic [QUEUE_PTR_W-1:0]  rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]  count_ff;
   logic [QUEUE_CNT_W-1:0]  count_in;

   assign status.full  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign pop_entry    = slot_ff[rd_ptr_ff];

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Hold item data
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

@@ rtl/mvsm_back.sv @@
`timescale 1ns / 1ps
// Back part of the mixer: sample memory, voice table, effect mix, result register.
// Depends on mvsm_pkg; takes items from mvsm_queue.
module mvsm_back import mvsm_pkg::*; #(
   parameter int VOICES       = VOICES_DEF,
   parameter int SAMPLE_WORDS = SAMPLE_WORDS_DEF,
   parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_valid,
   input  logic [DIV_W-1:0]    csr_effect_divider,
   input  queue_status_type    q_status,
   input  entry_type           entry,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [AUDIO_W-1:0]  rsp_audio_value,
   output logic                rsp_audio_valid,
   output logic                rsp_start_refused,
   output logic [USED_W-1:0]   rsp_voice_used
);

   localparam int VIW   = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int AW    = $clog2(SAMPLE_WORDS);
   localparam int SUM_W = SAMPLE_BITS + $clog2(VOICES + 1);
   localparam int DBL_W = SUM_W + 1;

   back_state_type state_ff;
   back_state_type state_in;

   // Voice table
   logic                    active_ff [VOICES];
   logic                    active_in [VOICES];
   logic [ADDR_W-1:0]       base_ff   [VOICES];
   logic [LEN_W-1:0]        length_ff [VOICES];
   logic [LEN_W-1:0]        pos_ff    [VOICES];

   logic [VIW-1:0]          v_ff;
   logic [VIW-1:0]          v_in;
   logic [SUM_W-1:0]        sum_ff;
   logic [SUM_W-1:0]        sum_in;
   logic [DIV_W-1:0]        countdown_ff;
   logic [DIV_W-1:0]        countdown_in;
   logic [DIV_W-1:0]        divider_ff;
   logic [HELD_W-1:0]       held_ff;
   logic [HELD_W-1:0]       held_in;
   logic [SONG_HALF_W-1:0]  song_half_ff;
   logic [SONG_HALF_W-1:0]  song_half_in;

   // Sample memory
   logic [SAMPLE_BITS-1:0]  sample_mem [SAMPLE_WORDS];
   logic [SAMPLE_BITS-1:0]  rd_data_ff;
   logic [AW-1:0]           mem_addr;
   logic [ADDR_SUM_W-1:0]   wrap_src;
   logic                    mem_we;
   logic                    mem_re;

   // Result register
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic [AUDIO_W-1:0]      audio_ff;
   logic [AUDIO_W-1:0]      audio_in;
   logic                    audio_valid_ff;
   logic                    audio_valid_in;
   logic                    refused_ff;
   logic                    refused_in;
   logic [USED_W-1:0]       used_ff;
   logic [USED_W-1:0]       used_in;

   logic                    out_free;
   logic                    last_voice;
   logic                    free_found;
   logic [VIW-1:0]          free_idx;
   logic                    start_ok;
   logic                    voice_write;
   logic [LEN_W-1:0]        pos_next;
   logic                    voice_done;
   logic [DBL_W-1:0]        sum_dbl;
   logic [HELD_W-1:0]       held_sat;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign pop        = (state_ff == BK_IDLE) && !q_status.empty && out_free;
   assign last_voice = (v_ff == VIW'(VOICES - 1));
   assign start_ok   = free_found && !entry.length_zero;
   assign voice_write = pop && (entry.op == OP_START) && start_ok;
   assign pos_next   = pos_ff[v_ff] + 1'b1;
   assign voice_done = (pos_next == length_ff[v_ff]);

   // Pick the lowest free voice
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = 0; i < VOICES; i++) begin
         if (!free_found && !active_ff[i]) begin
            free_found = 1'b1;
            free_idx   = VIW'(i);
         end
      end
   end

   // Wrap load address or voice read address into the store
   assign wrap_src = (state_ff == BK_IDLE) ? ADDR_SUM_W'(entry.address)
                                           : ADDR_SUM_W'(base_ff[v_ff]) +
                                             ADDR_SUM_W'(pos_ff[v_ff]);
   assign mem_addr = AW'(wrap_addr(wrap_src, SAMPLE_WORDS));
   assign mem_we   = pop && (entry.op == OP_LOAD);
   assign mem_re   = (state_ff == BK_READ) && active_ff[v_ff];

   // Saturate twice the effect sum
   assign sum_dbl = {sum_ff, 1'b0};
   always_comb begin
      if (32'(sum_dbl) > 32'(HELD_MAX)) begin
         held_sat = HELD_MAX;
      end else begin
         held_sat = HELD_W'(sum_dbl);
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (pop && entry.op == OP_TICK && countdown_ff == '0) begin
               state_in = BK_READ;
            end
         end
         BK_READ: begin
            if (active_ff[v_ff]) begin
               state_in = BK_ACC;
            end else if (last_voice) begin
               state_in = BK_DONE;
            end
         end
         BK_ACC: begin
            state_in = last_voice ? BK_DONE : BK_READ;
         end
         BK_DONE: begin
            state_in = BK_IDLE;
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // Datapath and result values per state
   always_comb begin
      v_in           = v_ff;
      sum_in         = sum_ff;
      countdown_in   = countdown_ff;
      held_in        = held_ff;
      song_half_in   = song_half_ff;
      active_in      = active_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      audio_in       = audio_ff;
      audio_valid_in = audio_valid_ff;
      refused_in     = refused_ff;
      used_in        = used_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (pop) begin
               rsp_valid_in   = 1'b1;
               audio_in       = '0;
               audio_valid_in = 1'b0;
               refused_in     = 1'b0;
               used_in        = '0;
               case (entry.op)
                  OP_START: begin
                     if (start_ok) begin
                        active_in[free_idx] = 1'b1;
                        used_in             = USED_W'(free_idx);
                     end else begin
                        refused_in = 1'b1;
                     end
                  end
                  OP_TICK: begin
                     if (countdown_ff == '0) begin
                        rsp_valid_in = 1'b0;
                        countdown_in = divider_ff;
                        song_half_in = entry.song_half;
                        v_in         = '0;
                        sum_in       = '0;
                     end else begin
                        countdown_in   = countdown_ff - 1'b1;
                        audio_in       = AUDIO_W'(entry.song_half) + AUDIO_W'(held_ff);
                        audio_valid_in = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         BK_READ: begin
            if (!active_ff[v_ff] && !last_voice) begin
               v_in = v_ff + 1'b1;
            end
         end
         BK_ACC: begin
            sum_in = sum_ff + SUM_W'(rd_data_ff);
            if (voice_done) begin
               active_in[v_ff] = 1'b0;
            end
            if (!last_voice) begin
               v_in = v_ff + 1'b1;
            end
         end
         BK_DONE: begin
            held_in        = held_sat;
            rsp_valid_in   = 1'b1;
            audio_in       = AUDIO_W'(song_half_ff) + AUDIO_W'(held_sat);
            audio_valid_in = 1'b1;
            refused_in     = 1'b0;
            used_in        = '0;
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         countdown_ff <= '0;
         held_ff      <= '0;
         divider_ff   <= DIVIDER_RESET;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < VOICES; i++) begin
            active_ff[i] <= 1'b0;
         end
      end else begin
         state_ff     <= state_in;
         countdown_ff <= countdown_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
         active_ff    <= active_in;
         if (csr_valid) begin
            divider_ff <= csr_effect_divider;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      v_ff           <= v_in;
      sum_ff         <= sum_in;
      song_half_ff   <= song_half_in;
      audio_ff       <= audio_in;
      audio_valid_ff <= audio_valid_in;
      refused_ff     <= refused_in;
      used_ff        <= used_in;
      if (voice_write) begin
         base_ff[free_idx]   <= entry.address;
         length_ff[free_idx] <= entry.effect_length;
         pos_ff[free_idx]    <= '0;
      end
      if (state_ff == BK_ACC) begin
         pos_ff[v_ff] <= pos_next;
      end
   end

   // Sample memory, one port, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         sample_mem[mem_addr] <= SAMPLE_BITS'(entry.sample_value);
      end
      if (mem_re) begin
         rd_data_ff <= sample_mem[mem_addr];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_audio_value   = audio_ff;
   assign rsp_audio_valid   = audio_valid_ff;
   assign rsp_start_refused = refused_ff;
   assign rsp_voice_used    = used_ff;

endmodule

@@ rtl/multi_voice_sample_mixer_unit.sv @@
`timescale 1ns / 1ps
// An accepted item passes a queue slot, then the result register; a tick that
// recomputes the mix also passes READ per voice, ACC per active one and DONE.
// Throughput: one item per cycle while rsp_ready allows, except a mixing tick,
// which holds the back until DONE, bounded by the one sample memory read port.
// Reset: synchronous, clears voices, countdown, held mix, queue; divider -> 4.
// Sample memory is not cleared; the user must read only where it was written.
module multi_voice_sample_mixer_unit import mvsm_pkg::*; #(
   parameter int VOICES       = VOICES_DEF,
   parameter int SAMPLE_WORDS = SAMPLE_WORDS_DEF,
   parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [DIV_W-1:0]    csr_effect_divider,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [MODE_W-1:0]   req_mode,
   input  logic [ADDR_W-1:0]   req_address,
   input  logic [SVAL_W-1:0]   req_sample_value,
   input  logic [LEN_W-1:0]    req_effect_length,
   input  logic [SONG_W-1:0]   req_song_sample,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [AUDIO_W-1:0]  rsp_audio_value,
   output logic                rsp_audio_valid,
   output logic                rsp_start_refused,
   output logic [USED_W-1:0]   rsp_voice_used
);

   queue_status_type q_status;
   entry_type        push_entry;
   entry_type        pop_entry;
   logic             push;
   logic             pop;

   assign csr_ready = 1'b1;

   // Classify incoming items
   mvsm_front u_front (
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_address       (req_address),
      .req_sample_value  (req_sample_value),
      .req_effect_length (req_effect_length),
      .req_song_sample   (req_song_sample),
      .q_status          (q_status),
      .push              (push),
      .push_entry        (push_entry)
   );

   // Decouple front and back
   mvsm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .status     (q_status)
   );

   // Execute items and drive results
   mvsm_back #(
      .VOICES       (VOICES),
      .SAMPLE_WORDS (SAMPLE_WORDS),
      .SAMPLE_BITS  (SAMPLE_BITS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_effect_divider (csr_effect_divider),
      .q_status           (q_status),
      .entry              (pop_entry),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_audio_value    (rsp_audio_value),
      .rsp_audio_valid    (rsp_audio_valid),
      .rsp_start_refused  (rsp_start_refused),
      .rsp_voice_used     (rsp_voice_used)
   );

endmodule
